### rtl/core/nsb_pkg.sv
// Package for the named semaphore bank: sizes, codes and the payload types.
package nsb_pkg;

    // Sizes of the bank.
    localparam int SEM_COUNT  = 16;
    localparam int NAME_BYTES = 5;
    localparam int COUNT_BITS = 16;

    // Fixed field widths of the request and response.
    localparam int OP_W       = 3;
    localparam int SEM_NAME_W = 40;
    localparam int INIT_W     = 16;
    localparam int SLOT_W     = 4;
    localparam int STATUS_W   = 3;

    // Derived widths.
    localparam int NAME_W     = NAME_BYTES * 8;
    localparam int NAME_EXT_W = (NAME_W > SEM_NAME_W) ? NAME_W : SEM_NAME_W;
    localparam int IDX_W      = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
    localparam int CMP_W      = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int REF_W      = 8;

    localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

    // Operation codes; the two remaining codes are undefined.
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 3'd0,
        OP_FIND   = 3'd1,
        OP_DUP    = 3'd2,
        OP_CLOSE  = 3'd3,
        OP_WAIT   = 3'd4,
        OP_SIGNAL = 3'd5
    } t_op;

    // Status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_NONE    = 3'd1,
        ST_ZERO    = 3'd2,
        ST_LIMIT   = 3'd3,
        ST_UNUSED  = 3'd4,
        ST_REFFULL = 3'd5
    } t_status;

    // Request as it arrives at the port.
    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [SEM_NAME_W-1:0] sem_name;
        logic [INIT_W-1:0]     init_count;
        logic [INIT_W-1:0]     limit_count;
        logic [SLOT_W-1:0]     slot;
    } t_req;

    // Response as it leaves the port.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic                wake;
    } t_rsp;

    // Token that travels down the chain of cells with the partial result.
    typedef struct packed {
        logic                  done;
        t_op                   op;
        logic [NAME_W-1:0]     name;
        logic [COUNT_BITS-1:0] init;
        logic [COUNT_BITS-1:0] limit;
        logic [SLOT_W-1:0]     slot;
        t_status               status;
        logic [SLOT_W-1:0]     slot_out;
        logic                  wake;
    } t_tok;

endpackage

### rtl/core/nsb_cell.sv
// One semaphore slot of the chain: holds its state and acts on the passing token.
module nsb_cell
    import nsb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  logic             i_valid,
    input  t_tok             i_tok,
    output logic             o_valid,
    output t_tok             o_tok
);

    // Slot state.
    logic [REF_W-1:0]      r_ref, n_ref;
    logic [NAME_W-1:0]     r_name, n_name;
    logic [COUNT_BITS-1:0] r_cur, n_cur;
    logic [COUNT_BITS-1:0] r_max, n_max;

    // Token register towards the next cell.
    logic r_valid;
    t_tok r_tok, n_tok;

    logic w_hit;

    // The token addresses this cell when its slot number equals the cell index.
    assign w_hit = (CMP_W'(i_index) == CMP_W'(i_tok.slot));

    // Act on the token if it is still open, otherwise pass it on unchanged.
    always_comb begin
        n_ref  = r_ref;
        n_name = r_name;
        n_cur  = r_cur;
        n_max  = r_max;
        n_tok  = i_tok;
        if (i_valid && !i_tok.done) begin
            unique case (i_tok.op)
                OP_ALLOC: begin
                    if (r_ref == '0) begin
                        n_ref          = REF_W'(1);
                        n_name         = i_tok.name;
                        n_cur          = i_tok.init;
                        n_max          = i_tok.limit;
                        n_tok.done     = 1'b1;
                        n_tok.status   = ST_OK;
                        n_tok.slot_out = SLOT_W'(i_index);
                    end
                end
                OP_FIND: begin
                    if ((r_ref != '0) && (r_name == i_tok.name)) begin
                        n_tok.done     = 1'b1;
                        n_tok.status   = ST_OK;
                        n_tok.slot_out = SLOT_W'(i_index);
                    end
                end
                OP_DUP: begin
                    if (w_hit) begin
                        n_tok.done = 1'b1;
                        if (r_ref == '0) begin
                            n_tok.status = ST_UNUSED;
                        end else if (r_ref == REF_MAX) begin
                            n_tok.status = ST_REFFULL;
                        end else begin
                            n_ref        = r_ref + REF_W'(1);
                            n_tok.status = ST_OK;
                        end
                    end
                end
                OP_CLOSE: begin
                    if (w_hit) begin
                        n_tok.done = 1'b1;
                        if (r_ref == '0) begin
                            n_tok.status = ST_UNUSED;
                        end else begin
                            n_ref        = r_ref - REF_W'(1);
                            n_tok.status = ST_OK;
                            // The last close frees the slot and clears its counts.
                            if (r_ref == REF_W'(1)) begin
                                n_cur = '0;
                                n_max = '0;
                            end
                        end
                    end
                end
                OP_WAIT: begin
                    if (w_hit) begin
                        n_tok.done = 1'b1;
                        if (r_cur == '0) begin
                            n_tok.status = ST_ZERO;
                        end else begin
                            n_cur        = r_cur - COUNT_BITS'(1);
                            n_tok.status = ST_OK;
                        end
                    end
                end
                OP_SIGNAL: begin
                    if (w_hit) begin
                        n_tok.done = 1'b1;
                        if (r_cur >= r_max) begin
                            n_tok.status = ST_LIMIT;
                        end else begin
                            n_cur        = r_cur + COUNT_BITS'(1);
                            n_tok.status = ST_OK;
                            n_tok.wake   = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control state and counts, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref   <= '0;
            r_cur   <= '0;
            r_max   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_ref   <= n_ref;
            r_cur   <= n_cur;
            r_max   <= n_max;
            r_valid <= i_valid;
        end
    end

    // Name and token payload need no reset.
    always_ff @(posedge i_clk) begin
        r_name <= n_name;
        r_tok  <= n_tok;
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

### rtl/core/named_semaphore_bank.sv
// Top level of the named semaphore bank: request entry, cell chain and response buffer.
//
//   Channel   Handshake                  Payload   Direction
//   request   i_req_valid / o_req_ready  i_req     in
//   response  o_rsp_valid / i_rsp_ready  o_rsp     out
//
// Each request walks the chain of SEM_COUNT cells, one cell a cycle, and its
// response is registered in the response buffer after it leaves the last cell;
// a new request is taken only once the previous token has left the chain.
// A two-entry response buffer lets a request enter while a response waits.
// Reset is synchronous and active low; it frees every slot at once.
// Requests stall only while a request is in the chain or the buffer is full.
module named_semaphore_bank
    import nsb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    logic w_accept;
    logic w_pop;
    logic [NAME_W-1:0] w_name;
    t_tok w_entry;

    logic r_busy;
    logic r_head_valid;
    t_tok r_head;

    logic w_valid [SEM_COUNT+1];
    t_tok w_tok   [SEM_COUNT+1];
    logic w_tail_valid;
    t_rsp w_rsp;

    logic r_out_valid, n_out_valid;
    logic r_skid_valid, n_skid_valid;
    t_rsp r_out, n_out;
    t_rsp r_skid, n_skid;

    assign o_req_ready = !r_busy && !(r_out_valid && r_skid_valid);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_pop       = r_out_valid && i_rsp_ready;

    // Name normalisation: bytes from the first zero byte onwards are dropped.
    always_comb begin
        logic [NAME_EXT_W-1:0] v_ext;
        logic                  v_keep;
        v_ext  = NAME_EXT_W'(i_req.sem_name);
        v_keep = 1'b1;
        w_name = '0;
        for (int i = 0; i < NAME_BYTES; i++) begin
            if (v_ext[8*i +: 8] == 8'd0) begin
                v_keep = 1'b0;
            end
            if (v_keep) begin
                w_name[8*i +: 8] = v_ext[8*i +: 8];
            end
        end
    end

    // Entry token: undefined ops and out-of-range slots are settled here.
    always_comb begin
        w_entry          = '0;
        w_entry.op       = t_op'(i_req.op);
        w_entry.name     = w_name;
        w_entry.init     = COUNT_BITS'(i_req.init_count);
        w_entry.limit    = COUNT_BITS'(i_req.limit_count);
        w_entry.slot     = i_req.slot;
        w_entry.status   = ST_NONE;
        w_entry.slot_out = '0;
        w_entry.wake     = 1'b0;
        w_entry.done     = 1'b0;
        unique case (w_entry.op)
            OP_ALLOC, OP_FIND: begin
            end
            OP_DUP, OP_CLOSE, OP_WAIT, OP_SIGNAL: begin
                w_entry.slot_out = i_req.slot;
                if (32'(i_req.slot) >= 32'(SEM_COUNT)) begin
                    w_entry.done   = 1'b1;
                    w_entry.status = ST_UNUSED;
                end
            end
            default: begin
                w_entry.done = 1'b1;
            end
        endcase
    end

    // Busy flag and head valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_head_valid <= 1'b0;
        end else begin
            r_head_valid <= w_accept;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_tail_valid) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Head token payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_head <= w_entry;
        end
    end

    // Chain of slot cells.
    assign w_valid[0] = r_head_valid;
    assign w_tok[0]   = r_head;

    for (genvar g = 0; g < SEM_COUNT; g++) begin : g_cell
        nsb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_valid (w_valid[g]),
            .i_tok   (w_tok[g]),
            .o_valid (w_valid[g+1]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_tail_valid   = w_valid[SEM_COUNT];
    assign w_rsp.status   = w_tok[SEM_COUNT].status;
    assign w_rsp.slot_out = w_tok[SEM_COUNT].slot_out;
    assign w_rsp.wake     = w_tok[SEM_COUNT].wake;

    // Two-entry response buffer: pop first, then push into the first free entry.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (w_pop) begin
            n_out_valid  = r_skid_valid;
            n_out        = r_skid;
            n_skid_valid = 1'b0;
        end
        if (w_tail_valid) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = w_rsp;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = w_rsp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // A taken request keeps the chain busy until its token leaves.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("chain not marked busy after a request was taken");

    // A token leaving the chain always belongs to a taken request.
    a_tail_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail_valid |-> r_busy)
        else $error("token left the chain with no request outstanding");

    // The response buffer always has room for a token leaving the chain.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail_valid |-> !(r_out_valid && r_skid_valid))
        else $error("response buffer full when a token left the chain");

    // The skid entry is only used behind a waiting response.
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

endmodule
